// ===== design/tcld_pkg.sv =====
// Shared types, constants and label tables of the text command line decoder.
`default_nettype none

package tcld_pkg;

  localparam int unsigned LABEL_MAX_DEF  = 15;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned INDEX_W = 3;
  localparam int unsigned PARAM_W = 32;

  localparam int unsigned GROUP_N   = 4;
  localparam int unsigned SUB_N     = 11;
  localparam int unsigned NAME_MAX  = 12;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

  localparam logic [INDEX_W-1:0] IDX_NONE       = 3'd0;
  localparam logic [INDEX_W-1:0] IDX_TORQUE     = 3'd1;
  localparam logic [INDEX_W-1:0] IDX_IMU_LAST   = 3'd5;

  typedef enum logic [3:0] {
    SC_COLON,
    SC_DOT,
    SC_LBRACE,
    SC_RBRACE,
    SC_COMMA,
    SC_MINUS,
    SC_EOL,
    SC_DIGIT,
    SC_OTHER
  } sym_class_e;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    sym_class_e        cls;
  } sym_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_GROUP,
    PH_SUB,
    PH_TASK,
    PH_PARAM
  } phase_e;

  typedef enum logic [CODE_W-1:0] {
    CMD_OS_VERSION,
    CMD_OS_MEMORY,
    CMD_OS_KERNEL,
    CMD_OS_TASK,
    CMD_SYS_VERSION,
    CMD_SET_MODE,
    CMD_SET_RATE,
    CMD_SET_MOTOR,
    CMD_BAT_VOLTAGE,
    CMD_BAT_CALIB,
    CMD_IMU_CALIB
  } cmd_e;

  typedef enum logic [1:0] {
    DIR_COAST,
    DIR_BRAKE,
    DIR_FORWARD,
    DIR_REVERSE
  } dir_e;

  typedef struct packed {
    cmd_e                       code;
    logic [INDEX_W-1:0]         index;
    logic signed [PARAM_W-1:0]  value;
    logic                       brake;
    logic                       last;
  } result_t;

  function automatic logic [8*NAME_MAX-1:0] group_name(input int k);
    logic [8*NAME_MAX-1:0] name;
    case (k)
      0:       name = (8*NAME_MAX)'("OS");
      1:       name = (8*NAME_MAX)'("SYS");
      2:       name = (8*NAME_MAX)'("BATTERY");
      default: name = (8*NAME_MAX)'("CALIB");
    endcase
    return name;
  endfunction

  function automatic int group_len(input int k);
    int len;
    case (k)
      0:       len = 2;
      1:       len = 3;
      2:       len = 7;
      default: len = 5;
    endcase
    return len;
  endfunction

  function automatic logic [SUB_N-1:0] group_subs(input int k);
    logic [SUB_N-1:0] subs;
    case (k)
      0:       subs = 11'h00F;
      1:       subs = 11'h0F0;
      2:       subs = 11'h300;
      default: subs = 11'h400;
    endcase
    return subs;
  endfunction

  function automatic logic [8*NAME_MAX-1:0] sub_name(input int k);
    logic [8*NAME_MAX-1:0] name;
    case (k)
      0:       name = (8*NAME_MAX)'("Version");
      1:       name = (8*NAME_MAX)'("Memory");
      2:       name = (8*NAME_MAX)'("Kernel");
      3:       name = (8*NAME_MAX)'("Task");
      4:       name = (8*NAME_MAX)'("Version");
      5:       name = (8*NAME_MAX)'("SetMode");
      6:       name = (8*NAME_MAX)'("SetTM");
      7:       name = (8*NAME_MAX)'("SetMotor");
      8:       name = (8*NAME_MAX)'("Voltage");
      9:       name = (8*NAME_MAX)'("VoltageCalib");
      default: name = (8*NAME_MAX)'("IMU");
    endcase
    return name;
  endfunction

  function automatic int sub_len(input int k);
    int len;
    case (k)
      0:       len = 7;
      1:       len = 6;
      2:       len = 6;
      3:       len = 4;
      4:       len = 7;
      5:       len = 7;
      6:       len = 5;
      7:       len = 8;
      8:       len = 7;
      9:       len = 12;
      default: len = 3;
    endcase
    return len;
  endfunction

  // Names are right-aligned in the packed word, so the first character sits highest.
  function automatic logic [BYTE_W-1:0] name_char(input logic [8*NAME_MAX-1:0] name,
                                                  input int len, input int pos);
    logic [BYTE_W-1:0] ch;
    ch = '0;
    if (pos < len) begin
      ch = name[8*(len-1-pos) +: 8];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== design/tcld_if.sv =====
// Handshake channels of the decoder: received bytes in, decoded commands out.
`default_nettype none

interface tcld_rx_if;
  logic                        valid;
  logic                        ready;
  logic [tcld_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tcld_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [tcld_pkg::CODE_W-1:0]         command_code;
  logic [tcld_pkg::INDEX_W-1:0]        param_index;
  logic signed [tcld_pkg::PARAM_W-1:0] param_value;
  logic                                brake;
  logic                                last_of_command;

  modport source (output valid, output command_code, output param_index,
                  output param_value, output brake, output last_of_command,
                  input ready);
  modport sink (input valid, input command_code, input param_index,
                input param_value, input brake, input last_of_command,
                output ready);
endinterface

`default_nettype wire

// ===== design/tcld_front.sv =====
// Front end: accepts received bytes and tags each with its character class.
`default_nettype none

module tcld_front (
  tcld_rx_if.sink          rx_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output tcld_pkg::sym_t   q_sym_o
);

  function automatic tcld_pkg::sym_class_e classify(input logic [tcld_pkg::BYTE_W-1:0] c);
    tcld_pkg::sym_class_e cls;
    if (c >= tcld_pkg::CH_ZERO && c <= tcld_pkg::CH_NINE) begin
      cls = tcld_pkg::SC_DIGIT;
    end else begin
      unique case (c)
        tcld_pkg::CH_COLON:               cls = tcld_pkg::SC_COLON;
        tcld_pkg::CH_DOT:                 cls = tcld_pkg::SC_DOT;
        tcld_pkg::CH_LBRACE:              cls = tcld_pkg::SC_LBRACE;
        tcld_pkg::CH_RBRACE:              cls = tcld_pkg::SC_RBRACE;
        tcld_pkg::CH_COMMA:               cls = tcld_pkg::SC_COMMA;
        tcld_pkg::CH_MINUS:               cls = tcld_pkg::SC_MINUS;
        tcld_pkg::CH_CR, tcld_pkg::CH_LF: cls = tcld_pkg::SC_EOL;
        default:                          cls = tcld_pkg::SC_OTHER;
      endcase
    end
    return cls;
  endfunction

  assign rx_i.ready        = !q_full_i;
  assign q_push_o          = rx_i.valid && !q_full_i;
  assign q_sym_o.rx_byte   = rx_i.rx_byte;
  assign q_sym_o.cls       = classify(rx_i.rx_byte);

endmodule

`default_nettype wire

// ===== design/tcld_queue.sv =====
// Short queue of classified bytes between the front end and the parser.
`default_nettype none

module tcld_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcld_pkg::sym_t push_sym_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tcld_pkg::sym_t pop_sym_o
);

  localparam int unsigned Depth = tcld_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  tcld_pkg::sym_t  entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o    = (count_q == CntFull);
  assign valid_o   = (count_q != '0);
  assign pop_sym_o = entry_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_sym_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/tcld_back.sv =====
// Back end: label matching, parameter parsing and the registered result stage.
`default_nettype none

module tcld_back #(
  parameter int unsigned LABEL_MAX  = tcld_pkg::LABEL_MAX_DEF,
  parameter int unsigned VALUE_BITS = tcld_pkg::VALUE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  tcld_pkg::sym_t q_sym_i,
  output logic           q_pop_o,
  tcld_cmd_if.source     cmd_o
);

  localparam int unsigned LenW   = $clog2(LABEL_MAX + 2);
  localparam logic [LenW-1:0] LenSat = LenW'(LABEL_MAX + 1);
  localparam int unsigned AccW   = VALUE_BITS - 1;
  localparam int unsigned PW     = tcld_pkg::PARAM_W;
  localparam int unsigned GroupN = tcld_pkg::GROUP_N;
  localparam int unsigned SubN   = tcld_pkg::SUB_N;
  localparam logic signed [VALUE_BITS-1:0] VOne = VALUE_BITS'(1);
  localparam logic signed [VALUE_BITS-1:0] VTwo = VALUE_BITS'(2);

  tcld_pkg::phase_e     phase_q, phase_d;
  logic [GroupN-1:0]    grp_mask_q, grp_mask_d;
  logic [SubN-1:0]      sub_mask_q, sub_mask_d;
  logic [LenW-1:0]      len_q, len_d;
  tcld_pkg::cmd_e       sel_q, sel_d;
  logic [AccW-1:0]      acc_q, acc_d;
  logic                 neg_q, neg_d;
  logic                 bad_q, bad_d;
  logic                 started_q, started_d;
  logic [2:0]           done_q, done_d;
  tcld_pkg::dir_e       dir_q, dir_d;
  logic                 out_valid_q, out_valid_d;
  tcld_pkg::result_t    res_q, res_d;

  logic                       step;
  logic                       emit;
  logic [7:0]                 c;
  tcld_pkg::sym_class_e       cls;
  logic                       is_end;
  logic [GroupN-1:0]          grp_narrow;
  logic [SubN-1:0]            sub_narrow;
  logic                       grp_hit;
  logic [1:0]                 grp_idx;
  logic                       sub_hit;
  logic [3:0]                 sub_idx;
  logic [LenW-1:0]            len_inc;
  logic [AccW+3:0]            prod;
  logic [AccW-1:0]            acc_dig;
  logic signed [VALUE_BITS-1:0] mag;
  logic signed [VALUE_BITS-1:0] v;
  logic signed [VALUE_BITS-1:0] res_v;

  assign c       = q_sym_i.rx_byte;
  assign cls     = q_sym_i.cls;
  assign is_end  = (cls == tcld_pkg::SC_DOT) || (cls == tcld_pkg::SC_EOL);
  assign step    = q_valid_i && (!out_valid_q || cmd_o.ready);
  assign q_pop_o = step;
  assign len_inc = (len_q < LenSat) ? len_q + 1'b1 : len_q;

  // Decimal accumulate with saturation at the largest positive value.
  assign prod    = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (AccW+4)'(c[3:0]);
  assign acc_dig = (|prod[AccW+3:AccW]) ? {AccW{1'b1}} : prod[AccW-1:0];

  assign mag = signed'({1'b0, acc_q});
  assign v   = bad_q ? '0 : (neg_q ? -mag : mag);

  always_comb begin
    grp_hit = 1'b0;
    grp_idx = '0;
    for (int k = GroupN - 1; k >= 0; k--) begin
      grp_narrow[k] = grp_mask_q[k] && (int'(len_q) < tcld_pkg::group_len(k)) &&
                      (tcld_pkg::name_char(tcld_pkg::group_name(k), tcld_pkg::group_len(k),
                                           int'(len_q)) == c);
      if (grp_mask_q[k] && int'(len_q) == tcld_pkg::group_len(k) &&
          int'(len_q) <= int'(LABEL_MAX)) begin
        grp_hit = 1'b1;
        grp_idx = 2'(k);
      end
    end
  end

  always_comb begin
    sub_hit = 1'b0;
    sub_idx = '0;
    for (int k = SubN - 1; k >= 0; k--) begin
      sub_narrow[k] = sub_mask_q[k] && (int'(len_q) < tcld_pkg::sub_len(k)) &&
                      (tcld_pkg::name_char(tcld_pkg::sub_name(k), tcld_pkg::sub_len(k),
                                           int'(len_q)) == c);
      if (sub_mask_q[k] && int'(len_q) == tcld_pkg::sub_len(k) &&
          int'(len_q) <= int'(LABEL_MAX)) begin
        sub_hit = 1'b1;
        sub_idx = 4'(k);
      end
    end
  end

  always_comb begin
    phase_d    = phase_q;
    grp_mask_d = grp_mask_q;
    sub_mask_d = sub_mask_q;
    len_d      = len_q;
    sel_d      = sel_q;
    acc_d      = acc_q;
    neg_d      = neg_q;
    bad_d      = bad_q;
    started_d  = started_q;
    done_d     = done_q;
    dir_d      = dir_q;
    emit       = 1'b0;
    res_v      = '0;
    res_d      = res_q;
    res_d.index = tcld_pkg::IDX_NONE;
    res_d.brake = 1'b0;
    res_d.last  = 1'b1;
    res_d.code  = sel_q;

    if (step) begin
      unique case (phase_q)
        tcld_pkg::PH_GROUP: begin
          if (is_end) begin
            if (cls == tcld_pkg::SC_DOT && grp_hit) begin
              sub_mask_d = tcld_pkg::group_subs(int'(grp_idx));
              len_d      = '0;
              phase_d    = tcld_pkg::PH_SUB;
            end else begin
              phase_d = tcld_pkg::PH_HUNT;
            end
          end else begin
            grp_mask_d = grp_narrow;
            len_d      = len_inc;
          end
        end

        tcld_pkg::PH_SUB: begin
          if (!is_end) begin
            sub_mask_d = sub_narrow;
            len_d      = len_inc;
          end else begin
            phase_d = tcld_pkg::PH_HUNT;
            if (sub_hit) begin
              sel_d      = tcld_pkg::cmd_e'(sub_idx);
              acc_d      = '0;
              neg_d      = 1'b0;
              bad_d      = 1'b0;
              started_d  = 1'b0;
              done_d     = '0;
              res_d.code = tcld_pkg::cmd_e'(sub_idx);
              case (tcld_pkg::cmd_e'(sub_idx)) inside
                tcld_pkg::CMD_OS_VERSION, tcld_pkg::CMD_OS_MEMORY, tcld_pkg::CMD_OS_KERNEL,
                tcld_pkg::CMD_SYS_VERSION, tcld_pkg::CMD_BAT_VOLTAGE: begin
                  emit = 1'b1;
                end
                tcld_pkg::CMD_OS_TASK: begin
                  phase_d = tcld_pkg::PH_TASK;
                end
                default: begin
                  phase_d = tcld_pkg::PH_PARAM;
                end
              endcase
            end
          end
        end

        tcld_pkg::PH_TASK: begin
          if (cls == tcld_pkg::SC_DIGIT) begin
            acc_d = acc_dig;
          end else begin
            phase_d = tcld_pkg::PH_HUNT;
            emit    = 1'b1;
            res_v   = mag;
          end
        end

        tcld_pkg::PH_PARAM: begin
          if (!started_q && (cls == tcld_pkg::SC_DOT || cls == tcld_pkg::SC_LBRACE)) begin
            started_d = 1'b0;
          end else if (!(cls == tcld_pkg::SC_COMMA || cls == tcld_pkg::SC_RBRACE ||
                         cls == tcld_pkg::SC_EOL)) begin
            if (cls == tcld_pkg::SC_MINUS) begin
              neg_d = 1'b1;
            end else if (cls == tcld_pkg::SC_DIGIT) begin
              acc_d = acc_dig;
            end else begin
              bad_d = 1'b1;
            end
            started_d = 1'b1;
          end else begin
            acc_d     = '0;
            neg_d     = 1'b0;
            bad_d     = 1'b0;
            started_d = 1'b0;
            unique case (sel_q)
              tcld_pkg::CMD_SET_MODE: begin
                phase_d = tcld_pkg::PH_HUNT;
                emit    = 1'b1;
                res_v   = (v == VOne || v == VTwo) ? v : '0;
              end
              tcld_pkg::CMD_SET_RATE: begin
                phase_d = tcld_pkg::PH_HUNT;
                emit    = 1'b1;
                res_v   = v[VALUE_BITS-1] ? '0 : v;
              end
              tcld_pkg::CMD_SET_MOTOR: begin
                if (done_q == '0) begin
                  done_d = 3'd1;
                  if (!v[VALUE_BITS-1] && v <= VTwo) begin
                    dir_d = tcld_pkg::dir_e'(v[1:0]);
                  end else begin
                    dir_d = tcld_pkg::DIR_REVERSE;
                  end
                end else begin
                  phase_d     = tcld_pkg::PH_HUNT;
                  done_d      = '0;
                  emit        = 1'b1;
                  res_d.index = tcld_pkg::IDX_TORQUE;
                  unique case (dir_q)
                    tcld_pkg::DIR_COAST:   res_v = '0;
                    tcld_pkg::DIR_BRAKE: begin
                      res_v       = '0;
                      res_d.brake = 1'b1;
                    end
                    tcld_pkg::DIR_FORWARD: res_v = v;
                    default:               res_v = -v;
                  endcase
                end
              end
              tcld_pkg::CMD_BAT_CALIB: begin
                phase_d = tcld_pkg::PH_HUNT;
                emit    = 1'b1;
                res_v   = v;
              end
              default: begin
                emit  = 1'b1;
                res_v = v;
                if (done_q >= tcld_pkg::IDX_IMU_LAST) begin
                  phase_d     = tcld_pkg::PH_HUNT;
                  done_d      = '0;
                  res_d.index = tcld_pkg::IDX_IMU_LAST;
                end else begin
                  done_d      = done_q + 1'b1;
                  res_d.index = done_q;
                  res_d.last  = 1'b0;
                end
              end
            endcase
          end
        end

        default: begin
          if (cls == tcld_pkg::SC_COLON) begin
            grp_mask_d = '1;
            len_d      = '0;
            phase_d    = tcld_pkg::PH_GROUP;
          end
        end
      endcase
    end

    res_d.value = PW'(res_v);
    out_valid_d = out_valid_q && !cmd_o.ready;
    if (step) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tcld_pkg::PH_HUNT;
      grp_mask_q  <= '1;
      sub_mask_q  <= '1;
      len_q       <= '0;
      sel_q       <= tcld_pkg::CMD_OS_VERSION;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      bad_q       <= 1'b0;
      started_q   <= 1'b0;
      done_q      <= '0;
      dir_q       <= tcld_pkg::DIR_COAST;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      grp_mask_q  <= grp_mask_d;
      sub_mask_q  <= sub_mask_d;
      len_q       <= len_d;
      sel_q       <= sel_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      bad_q       <= bad_d;
      started_q   <= started_d;
      done_q      <= done_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      res_q <= res_d;
    end
  end

  assign cmd_o.valid           = out_valid_q;
  assign cmd_o.command_code    = res_q.code;
  assign cmd_o.param_index     = res_q.index;
  assign cmd_o.param_value     = res_q.value;
  assign cmd_o.brake           = res_q.brake;
  assign cmd_o.last_of_command = res_q.last;

endmodule

`default_nettype wire

// ===== design/text_command_line_decoder.sv =====
// Top level of the text command line decoder.
`default_nettype none

// Decodes a stream of received characters of the form :GROUP.Subcommand.{v1,v2,...}
// into command items, one byte per clock cycle sustained while results are taken. A
// front end tags each accepted byte with its character class and writes it into a
// two-entry queue; the parser drains the queue at one byte per cycle while no result
// waits, and its per-byte state update sets the rate. A result is written into the
// output register at the same edge at which its byte leaves the queue, so the byte
// that completes an item passes the queue entry, then the output register. While a
// result waits, the queue keeps accepting bytes until it is full. Labels longer than
// LABEL_MAX never match, and decimal magnitudes saturate at 2^(VALUE_BITS-1)-1.
module text_command_line_decoder #(
  parameter int unsigned LABEL_MAX  = tcld_pkg::LABEL_MAX_DEF,
  parameter int unsigned VALUE_BITS = tcld_pkg::VALUE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcld_rx_if.sink    rx_i,
  tcld_cmd_if.source cmd_o
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  tcld_pkg::sym_t push_sym;
  tcld_pkg::sym_t pop_sym;

  tcld_front u_front (
    .rx_i     (rx_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_sym_o  (push_sym)
  );

  tcld_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_sym_i (push_sym),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_sym_o  (pop_sym)
  );

  tcld_back #(
    .LABEL_MAX  (LABEL_MAX),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_sym_i   (pop_sym),
    .q_pop_o   (q_pop),
    .cmd_o     (cmd_o)
  );

endmodule

`default_nettype wire

// ===== tb/text_command_line_decoder_tb.sv =====
// Self-checking testbench of the text command line decoder, with a byte-level parser model.
`timescale 1ns / 1ps

module text_command_line_decoder_tb;

  localparam int STIM_BYTES = 1450;
  localparam int HOLD_LEN   = 400;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_WAIT = 20;
  localparam logic [63:0] MAG_MAX = (64'd1 << (tcld_pkg::VALUE_BITS_DEF - 1)) - 64'd1;

  typedef struct {
    logic [tcld_pkg::BYTE_W-1:0] data;
    bit                          drain;
  } rx_item_t;

  logic clk;
  logic rst_n;

  tcld_rx_if  rx_if ();
  tcld_cmd_if cmd_if ();

  text_command_line_decoder u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_if),
    .cmd_o  (cmd_if)
  );

  string       grp_label [4]  = '{"OS", "SYS", "BATTERY", "CALIB"};
  string       sub_label [11] = '{"Version", "Memory", "Kernel", "Task", "Version", "SetMode",
                                  "SetTM", "SetMotor", "Voltage", "VoltageCalib", "IMU"};
  int          grp_of [11]    = '{0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 3};
  logic [10:0] grp_subs [4]   = '{11'h00F, 11'h0F0, 11'h300, 11'h400};
  string       big_vals [5]   = '{"2147483647", "2147483648", "-2147483647",
                                  "99999999999999", "-00000000000"};

  rx_item_t                    rx_stream [$];
  logic [tcld_pkg::BYTE_W-1:0] frame [$];
  tcld_pkg::result_t           pending_cmds [$];
  bit                          drain_next;

  tcld_pkg::phase_e  dec_phase;
  logic [3:0]        grp_live;
  logic [10:0]       sub_live;
  logic [4:0]        label_len;
  tcld_pkg::cmd_e    cur_cmd;
  logic [63:0]       acc_mag;
  bit                minus_seen;
  bit                junk_seen;
  bit                val_started;
  logic [2:0]        param_count;
  tcld_pkg::dir_e    motor_dir;

  int errors;
  int n_total;
  int n_accepted;
  int n_results;
  int gap_left;
  int tx_burst;
  int stall_left;
  int rd_burst;
  int idle_cycles;
  bit hold_req;

  always #5 clk = ~clk;

  function automatic int pick_idle(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst = $urandom_range(20, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [10:0] narrow_label(logic [10:0] mask, bit is_grp,
                                               logic [tcld_pkg::BYTE_W-1:0] c,
                                               logic [4:0] pos);
    string nm;
    int cnt;
    cnt = is_grp ? 4 : 11;
    for (int k = 0; k < cnt; k++) begin
      nm = is_grp ? grp_label[k] : sub_label[k];
      if (mask[k] && (pos >= nm.len() || nm[pos] != c)) mask[k] = 1'b0;
    end
    return mask;
  endfunction

  function automatic int exact_label(logic [10:0] mask, bit is_grp, logic [4:0] len);
    string nm;
    int cnt;
    cnt = is_grp ? 4 : 11;
    if (len > tcld_pkg::LABEL_MAX_DEF) return -1;
    for (int k = 0; k < cnt; k++) begin
      nm = is_grp ? grp_label[k] : sub_label[k];
      if (mask[k] && nm.len() == len) return k;
    end
    return -1;
  endfunction

  function automatic logic [63:0] add_digit(logic [63:0] a, logic [tcld_pkg::BYTE_W-1:0] c);
    logic [63:0] d;
    d = 64'(c - tcld_pkg::CH_ZERO);
    if (a > (MAG_MAX - d) / 10) return MAG_MAX;
    return a * 10 + d;
  endfunction

  function automatic bit is_digit(logic [tcld_pkg::BYTE_W-1:0] c);
    return c >= tcld_pkg::CH_ZERO && c <= tcld_pkg::CH_NINE;
  endfunction

  task automatic queue_cmd(tcld_pkg::cmd_e code, logic [tcld_pkg::INDEX_W-1:0] idx,
                           logic signed [63:0] v, bit brk, bit last);
    tcld_pkg::result_t r;
    r.code  = code;
    r.index = idx;
    r.value = v[tcld_pkg::PARAM_W-1:0];
    r.brake = brk;
    r.last  = last;
    pending_cmds.push_back(r);
  endtask

  task automatic clear_value();
    acc_mag     = '0;
    minus_seen  = 1'b0;
    junk_seen   = 1'b0;
    val_started = 1'b0;
  endtask

  task automatic decode_byte(logic [tcld_pkg::BYTE_W-1:0] c);
    int m;
    logic signed [63:0] v;
    bit eol;
    eol = (c == tcld_pkg::CH_DOT) || (c == tcld_pkg::CH_CR) || (c == tcld_pkg::CH_LF);
    case (dec_phase)
      tcld_pkg::PH_GROUP: begin
        if (eol) begin
          m = exact_label({7'd0, grp_live}, 1'b1, label_len);
          if (c == tcld_pkg::CH_DOT && m >= 0) begin
            sub_live  = grp_subs[m];
            label_len = '0;
            dec_phase = tcld_pkg::PH_SUB;
          end else begin
            dec_phase = tcld_pkg::PH_HUNT;
          end
        end else begin
          grp_live = 4'(narrow_label({7'd0, grp_live}, 1'b1, c, label_len));
          if (label_len < 5'd31) label_len++;
        end
      end
      tcld_pkg::PH_SUB: begin
        if (!eol) begin
          sub_live = narrow_label(sub_live, 1'b0, c, label_len);
          if (label_len < 5'd31) label_len++;
        end else begin
          m = exact_label(sub_live, 1'b0, label_len);
          dec_phase = tcld_pkg::PH_HUNT;
          if (m >= 0) begin
            cur_cmd = tcld_pkg::cmd_e'(m);
            clear_value();
            param_count = '0;
            case (cur_cmd)
              tcld_pkg::CMD_OS_VERSION, tcld_pkg::CMD_OS_MEMORY, tcld_pkg::CMD_OS_KERNEL,
              tcld_pkg::CMD_SYS_VERSION, tcld_pkg::CMD_BAT_VOLTAGE:
                queue_cmd(cur_cmd, tcld_pkg::IDX_NONE, 64'sd0, 1'b0, 1'b1);
              tcld_pkg::CMD_OS_TASK: dec_phase = tcld_pkg::PH_TASK;
              default: dec_phase = tcld_pkg::PH_PARAM;
            endcase
          end
        end
      end
      tcld_pkg::PH_TASK: begin
        if (is_digit(c)) begin
          acc_mag = add_digit(acc_mag, c);
        end else begin
          dec_phase = tcld_pkg::PH_HUNT;
          queue_cmd(tcld_pkg::CMD_OS_TASK, tcld_pkg::IDX_NONE, $signed(acc_mag), 1'b0, 1'b1);
        end
      end
      tcld_pkg::PH_PARAM: begin
        if (!val_started && (c == tcld_pkg::CH_DOT || c == tcld_pkg::CH_LBRACE)) begin
        end else if (!(c == tcld_pkg::CH_COMMA || c == tcld_pkg::CH_RBRACE ||
                       c == tcld_pkg::CH_CR || c == tcld_pkg::CH_LF)) begin
          if (c == tcld_pkg::CH_MINUS) minus_seen = 1'b1;
          else if (is_digit(c)) acc_mag = add_digit(acc_mag, c);
          else junk_seen = 1'b1;
          val_started = 1'b1;
        end else begin
          if (junk_seen) v = 64'sd0;
          else if (minus_seen) v = -$signed(acc_mag);
          else v = $signed(acc_mag);
          clear_value();
          case (cur_cmd)
            tcld_pkg::CMD_SET_MODE: begin
              dec_phase = tcld_pkg::PH_HUNT;
              queue_cmd(tcld_pkg::CMD_SET_MODE, tcld_pkg::IDX_NONE,
                        (v == 64'sd1 || v == 64'sd2) ? v : 64'sd0, 1'b0, 1'b1);
            end
            tcld_pkg::CMD_SET_RATE: begin
              dec_phase = tcld_pkg::PH_HUNT;
              queue_cmd(tcld_pkg::CMD_SET_RATE, tcld_pkg::IDX_NONE,
                        (v < 64'sd0) ? 64'sd0 : v, 1'b0, 1'b1);
            end
            tcld_pkg::CMD_SET_MOTOR: begin
              if (param_count == 3'd0) begin
                motor_dir   = (v >= 64'sd0 && v <= 64'sd2) ? tcld_pkg::dir_e'(v[1:0])
                                                           : tcld_pkg::DIR_REVERSE;
                param_count = 3'd1;
              end else begin
                dec_phase   = tcld_pkg::PH_HUNT;
                param_count = '0;
                case (motor_dir)
                  tcld_pkg::DIR_COAST:
                    queue_cmd(tcld_pkg::CMD_SET_MOTOR, tcld_pkg::IDX_TORQUE, 64'sd0, 1'b0, 1'b1);
                  tcld_pkg::DIR_BRAKE:
                    queue_cmd(tcld_pkg::CMD_SET_MOTOR, tcld_pkg::IDX_TORQUE, 64'sd0, 1'b1, 1'b1);
                  tcld_pkg::DIR_FORWARD:
                    queue_cmd(tcld_pkg::CMD_SET_MOTOR, tcld_pkg::IDX_TORQUE, v, 1'b0, 1'b1);
                  default:
                    queue_cmd(tcld_pkg::CMD_SET_MOTOR, tcld_pkg::IDX_TORQUE, -v, 1'b0, 1'b1);
                endcase
              end
            end
            tcld_pkg::CMD_BAT_CALIB: begin
              dec_phase = tcld_pkg::PH_HUNT;
              queue_cmd(tcld_pkg::CMD_BAT_CALIB, tcld_pkg::IDX_NONE, v, 1'b0, 1'b1);
            end
            default: begin
              if (param_count >= tcld_pkg::IDX_IMU_LAST) begin
                dec_phase   = tcld_pkg::PH_HUNT;
                param_count = '0;
                queue_cmd(tcld_pkg::CMD_IMU_CALIB, tcld_pkg::IDX_IMU_LAST, v, 1'b0, 1'b1);
              end else begin
                queue_cmd(tcld_pkg::CMD_IMU_CALIB, param_count, v, 1'b0, 1'b0);
                param_count++;
              end
            end
          endcase
        end
      end
      default: begin
        if (c == tcld_pkg::CH_COLON) begin
          grp_live  = 4'hF;
          label_len = '0;
          dec_phase = tcld_pkg::PH_GROUP;
        end else begin
          dec_phase = tcld_pkg::PH_HUNT;
        end
      end
    endcase
  endtask

  task automatic put(logic [tcld_pkg::BYTE_W-1:0] b);
    frame.push_back(b);
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic flush_frame(bit damage);
    int pos;
    if (damage && frame.size() > 1) begin
      pos = $urandom_range(1, frame.size() - 1);
      case ($urandom_range(0, 2))
        0: while (frame.size() > pos) void'(frame.pop_back());
        1: frame[pos] = 8'($urandom_range(0, 255));
        default: frame[pos] = frame[pos] ^ 8'h20;
      endcase
    end
    foreach (frame[i]) begin
      rx_stream.push_back('{frame[i], drain_next});
      drain_next = 1'b0;
    end
    frame.delete();
  endtask

  task automatic put_value(bit narrow);
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (narrow && r < 70) begin
      put(8'(tcld_pkg::CH_ZERO + $urandom_range(0, 3)));
    end else if (r < 6) begin
    end else if (r < 16) begin
      put_str(big_vals[$urandom_range(0, 4)]);
    end else begin
      if ($urandom_range(0, 3) == 0) put(tcld_pkg::CH_MINUS);
      n = (r < 50) ? $urandom_range(1, 3) : $urandom_range(4, 12);
      for (int i = 0; i < n; i++) begin
        put(8'(tcld_pkg::CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 29) == 0) begin
          put(8'($urandom_range(0, 1) ? tcld_pkg::CH_MINUS : $urandom_range(0, 255)));
        end
      end
    end
  endtask

  task automatic put_eol();
    put($urandom_range(0, 1) ? tcld_pkg::CH_CR : tcld_pkg::CH_LF);
  endtask

  task automatic build_cmd(int k);
    int nvals;
    int n;
    tcld_pkg::cmd_e code;
    code = tcld_pkg::cmd_e'(k);
    put(tcld_pkg::CH_COLON);
    put_str(grp_label[grp_of[k]]);
    put(tcld_pkg::CH_DOT);
    put_str(sub_label[k]);
    if ($urandom_range(0, 4) == 0) put_eol();
    else put(tcld_pkg::CH_DOT);
    case (code)
      tcld_pkg::CMD_OS_TASK: begin
        n = $urandom_range(0, 3) == 0 ? $urandom_range(5, 13) : $urandom_range(0, 4);
        for (int i = 0; i < n; i++) put(8'(tcld_pkg::CH_ZERO + $urandom_range(0, 9)));
        n = $urandom_range(0, 245);
        if (n >= tcld_pkg::CH_ZERO) n += 10;
        put(8'(n));
      end
      tcld_pkg::CMD_SET_MODE, tcld_pkg::CMD_SET_RATE, tcld_pkg::CMD_BAT_CALIB,
      tcld_pkg::CMD_SET_MOTOR, tcld_pkg::CMD_IMU_CALIB: begin
        nvals = (code == tcld_pkg::CMD_SET_MOTOR) ? 2 :
                (code == tcld_pkg::CMD_IMU_CALIB) ? 6 : 1;
        if ($urandom_range(0, 4) != 0) put(tcld_pkg::CH_LBRACE);
        for (int i = 0; i < nvals; i++) begin
          put_value(code == tcld_pkg::CMD_SET_MODE ||
                    (code == tcld_pkg::CMD_SET_MOTOR && i == 0));
          if ($urandom_range(0, 9) == 0) put_eol();
          else put(i == nvals - 1 ? tcld_pkg::CH_RBRACE : tcld_pkg::CH_COMMA);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic build_directed();
    put_str(":OS.Version.");
    put_str(":OS.Memory");
    put(tcld_pkg::CH_CR);
    put_str(":OS.Kernel");
    put(tcld_pkg::CH_LF);
    put_str(":OS.Task.2147483648.");
    put_str(":OS.Task.;");
    put_str(":SYS.Version.");
    put_str(":SYS.SetMode.{2}");
    put_str(":SYS.SetMode.{3}");
    put_str(":SYS.SetTM.{-5}");
    put_str(":SYS.SetTM.{99999999999}");
    put_str(":SYS.SetMotor.{0,5}");
    put_str(":SYS.SetMotor.{1,7}");
    put_str(":SYS.SetMotor.{2,-2147483647}");
    put_str(":SYS.SetMotor.{9,123}");
    put_str(":BATTERY.Voltage.");
    put_str(":BATTERY.VoltageCalib.{1a2}");
    put_str(":BATTERY.VoltageCalib.{12-3}");
    put_str(":CALIB.IMU.{1,-2,3");
    put(tcld_pkg::CH_CR);
    put_str("4,5,6}");
    put_str(":OS");
    put(tcld_pkg::CH_CR);
    put_str("Version.");
    put_str(":CALIBCALIBCALIBCA.IMU.");
    put_str(":SYS.SetModeSetModeSetMode.");
    put_str(":os.Version.");
    put_str(":O:S.Version.");
    put(8'h00);
    put(8'hFF);
    flush_frame(1'b0);
  endtask

  task automatic build_random();
    int r;
    int n;
    while (rx_stream.size() < STIM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) put(8'($urandom_range(0, 255)));
        flush_frame(1'b0);
      end else if (r < 12) begin
        put(tcld_pkg::CH_COLON);
        if ($urandom_range(0, 1)) put_str("CALIB.");
        n = $urandom_range(13, 24);
        for (int i = 0; i < n; i++) put(8'("A" + $urandom_range(0, 25)));
        put(tcld_pkg::CH_DOT);
        flush_frame(1'b0);
      end else begin
        build_cmd($urandom_range(0, 10));
        flush_frame($urandom_range(0, 99) < 15);
      end
      if ($urandom_range(0, 39) == 0) drain_next = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    rx_item_t nxt;
    if (rst_n) begin
      if (rx_if.valid && rx_if.ready) begin
        decode_byte(rx_if.rx_byte);
        n_accepted++;
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          rx_if.valid <= 1'b0;
        end else if (rx_stream.size() == 0 ||
                     (rx_stream[0].drain && pending_cmds.size() != 0)) begin
          rx_if.valid <= 1'b0;
        end else begin
          nxt = rx_stream.pop_front();
          rx_if.valid   <= 1'b1;
          rx_if.rx_byte <= nxt.data;
          gap_left = pick_idle(tx_burst);
        end
      end
    end
  end

  always @(posedge clk) begin
    tcld_pkg::result_t want;
    if (rst_n) begin
      if (cmd_if.valid && cmd_if.ready) begin
        n_results++;
        if (n_results == 10 || n_results == 80) hold_req = 1'b1;
        if (pending_cmds.size() == 0) begin
          errors++;
          $display("%0t: unexpected item code=%0d idx=%0d value=%0d brake=%0b last=%0b",
                   $time, cmd_if.command_code, cmd_if.param_index, cmd_if.param_value,
                   cmd_if.brake, cmd_if.last_of_command);
        end else begin
          want = pending_cmds.pop_front();
          if (cmd_if.command_code !== want.code || cmd_if.param_index !== want.index ||
              cmd_if.param_value !== want.value || cmd_if.brake !== want.brake ||
              cmd_if.last_of_command !== want.last) begin
            errors++;
            $display("%0t: mismatch expected code=%0d idx=%0d value=%0d brake=%0b last=%0b",
                     $time, want.code, want.index, want.value, want.brake, want.last);
            $display("%0t:          actual   code=%0d idx=%0d value=%0d brake=%0b last=%0b",
                     $time, cmd_if.command_code, cmd_if.param_index, cmd_if.param_value,
                     cmd_if.brake, cmd_if.last_of_command);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        cmd_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_LEN;
        cmd_if.ready <= 1'b0;
      end else begin
        cmd_if.ready <= 1'b1;
        stall_left = pick_idle(rd_burst);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((rx_if.valid && rx_if.ready) || (cmd_if.valid && cmd_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    cmd_if.ready  = 1'b0;
    dec_phase     = tcld_pkg::PH_HUNT;
    grp_live      = 4'hF;
    sub_live      = 11'h7FF;
    label_len     = '0;
    cur_cmd       = tcld_pkg::CMD_OS_VERSION;
    param_count   = '0;
    motor_dir     = tcld_pkg::DIR_COAST;
    clear_value();
    build_directed();
    drain_next = 1'b1;
    build_random();
    n_total = rx_stream.size();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (n_accepted < n_total) @(posedge clk);
    while (pending_cmds.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_cmds.size() > 0) begin
      errors += pending_cmds.size();
      $display("%0t: %0d expected items never arrived", $time, pending_cmds.size());
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
